// File: hw/rtl/eopg_pkg.sv
// shared types, constants and microcode encodings of the ellipse outline point generator
package eopg_pkg;

  localparam int COORD_BITS_DEF  = 12;
  localparam int RADIUS_BITS_DEF = 10;

  // microcode address width and entry points
  localparam int UA_W = 4;
  typedef logic [UA_W-1:0] uaddr_t;

  localparam uaddr_t UA_FETCH    = uaddr_t'(0);
  localparam uaddr_t UA_DISPATCH = uaddr_t'(1);
  localparam uaddr_t UA_START    = uaddr_t'(2);
  localparam uaddr_t UA_ZERO     = uaddr_t'(7);
  localparam uaddr_t UA_SINGLE   = uaddr_t'(8);
  localparam uaddr_t UA_R1       = uaddr_t'(9);
  localparam uaddr_t UA_R2       = uaddr_t'(12);

  // request opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_REGION1,
    PH_REGION2,
    PH_SINGLE
  } phase_t;

  // datapath operations
  typedef enum logic [3:0] {
    DP_NOP,
    DP_MUL_AA,
    DP_MUL_BB,
    DP_MUL_BBA,
    DP_MUL_AAB,
    DP_INIT_R1,
    DP_ZERO,
    DP_IDLE,
    DP_R1_Y,
    DP_R1_X,
    DP_R1_END,
    DP_R2_X,
    DP_R2_Y,
    DP_R2_END
  } dp_op_t;

  // result emission kind
  typedef enum logic [1:0] {
    EM_NONE,
    EM_SINGLE,
    EM_R1,
    EM_R2
  } emit_t;

  // sequencing condition
  typedef enum logic [2:0] {
    CJ_NEXT,
    CJ_GOTO,
    CJ_WAIT_IN,
    CJ_DISPATCH,
    CJ_ZERO
  } jcond_t;

  typedef struct packed {
    dp_op_t op;
    emit_t  emit;
    jcond_t cond;
    uaddr_t target;
  } ucode_word_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    phase_t phase;
    logic   step_op;
    logic   radii_zero;
  } dp_status_t;

endpackage

// File: hw/rtl/ellipse_outline_point_generator_unit.sv
// top level of the microcoded midpoint ellipse outline point generator
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------------
//   in_     | request   | in_valid/in_stall  | opcode, center_x/y, radius_h/v
//   out_    | result    | out_valid/out_stall| x_right, x_left, y_down, y_up, region, last
//
// one request at a time; the microcode returns to its fetch step after each one
// each request runs as a microcode program (start, region one or two step, single-point step,
// idle step) on the one shared multiplier/adder datapath
// reset (rst_n low, synchronous) puts the step counter at fetch, phase idle, output empty
// a finished point set sits in the output register; the next request is still taken,
// and only its emitting step waits while out_stall holds that register
module ellipse_outline_point_generator_unit import eopg_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_opcode,
  input  logic signed [COORD_BITS-1:0] in_center_x,
  input  logic signed [COORD_BITS-1:0] in_center_y,
  input  logic [RADIUS_BITS-1:0]       in_radius_h,
  input  logic [RADIUS_BITS-1:0]       in_radius_v,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS:0]   out_x_right,
  output logic signed [COORD_BITS:0]   out_x_left,
  output logic signed [COORD_BITS:0]   out_y_down,
  output logic signed [COORD_BITS:0]   out_y_up,
  output logic                         out_region,
  output logic                         out_last
);

  uaddr_t      ua_pc;
  ucode_word_t ucw;
  dp_status_t  dp_st;
  logic        fire;
  logic        out_busy;
  logic        in_accept;

  // requests are only taken at the fetch step
  assign in_stall  = (ua_pc != UA_FETCH);
  assign in_accept = in_valid && !in_stall;

  // control store lookup
  eopg_ucode_rom u_rom (
    .addr (ua_pc),
    .word (ucw)
  );

  // step counter, holds and jumps
  eopg_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_busy (out_busy),
    .cw       (ucw),
    .st       (dp_st),
    .pc       (ua_pc),
    .fire     (fire)
  );

  // arithmetic, walk state and result register
  eopg_datapath #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_accept   (in_accept),
    .in_opcode   (in_opcode),
    .in_center_x (in_center_x),
    .in_center_y (in_center_y),
    .in_radius_h (in_radius_h),
    .in_radius_v (in_radius_v),
    .cw          (ucw),
    .fire        (fire),
    .out_stall   (out_stall),
    .st          (dp_st),
    .out_busy    (out_busy),
    .out_valid   (out_valid),
    .out_x_right (out_x_right),
    .out_x_left  (out_x_left),
    .out_y_down  (out_y_down),
    .out_y_up    (out_y_up),
    .out_region  (out_region),
    .out_last    (out_last)
  );

`ifndef SYNTHESIS
  // an emitting step must not advance while the output register is blocked
  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall && ucw.emit != EM_NONE) |=> $stable(ua_pc))
    else $error("emitting step advanced over a stalled result");

  // a new result only comes from an emitting step that fired
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(fire && ucw.emit != EM_NONE))
    else $error("result appeared without an emitting step");

  // an accepted request is always dispatched next
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (ua_pc == UA_DISPATCH))
    else $error("accepted request was not dispatched");
`endif

endmodule

// File: hw/rtl/eopg_ucode_rom.sv
// control store: one control word per microcode step
module eopg_ucode_rom import eopg_pkg::*; (
  input  uaddr_t      addr,
  output ucode_word_t word
);

  always_comb begin
    unique case (addr)
      UA_FETCH:        word = '{DP_NOP,     EM_NONE,   CJ_WAIT_IN,  UA_FETCH};
      UA_DISPATCH:     word = '{DP_NOP,     EM_NONE,   CJ_DISPATCH, UA_FETCH};
      // squares and cross products on the shared multiplier
      UA_START:        word = '{DP_MUL_AA,  EM_NONE,   CJ_ZERO,     UA_ZERO};
      uaddr_t'(3):     word = '{DP_MUL_BB,  EM_NONE,   CJ_NEXT,     UA_FETCH};
      uaddr_t'(4):     word = '{DP_MUL_BBA, EM_NONE,   CJ_NEXT,     UA_FETCH};
      uaddr_t'(5):     word = '{DP_MUL_AAB, EM_NONE,   CJ_NEXT,     UA_FETCH};
      uaddr_t'(6):     word = '{DP_INIT_R1, EM_NONE,   CJ_GOTO,     UA_FETCH};
      UA_ZERO:         word = '{DP_ZERO,    EM_NONE,   CJ_GOTO,     UA_FETCH};
      UA_SINGLE:       word = '{DP_IDLE,    EM_SINGLE, CJ_GOTO,     UA_FETCH};
      // region one: emit, step y, maybe step x, check for region change
      UA_R1:           word = '{DP_R1_Y,    EM_R1,     CJ_NEXT,     UA_FETCH};
      uaddr_t'(10):    word = '{DP_R1_X,    EM_NONE,   CJ_NEXT,     UA_FETCH};
      uaddr_t'(11):    word = '{DP_R1_END,  EM_NONE,   CJ_GOTO,     UA_FETCH};
      // region two: step x, maybe step y, emit the old point
      UA_R2:           word = '{DP_R2_X,    EM_NONE,   CJ_NEXT,     UA_FETCH};
      uaddr_t'(13):    word = '{DP_R2_Y,    EM_NONE,   CJ_NEXT,     UA_FETCH};
      uaddr_t'(14):    word = '{DP_R2_END,  EM_R2,     CJ_GOTO,     UA_FETCH};
      default:         word = '{DP_NOP,     EM_NONE,   CJ_GOTO,     UA_FETCH};
    endcase
  end

endmodule

// File: hw/rtl/eopg_sequencer.sv
// step counter and jump logic of the microcode sequencer
module eopg_sequencer import eopg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        out_busy,
  input  ucode_word_t cw,
  input  dp_status_t  st,
  output uaddr_t      pc,
  output logic        fire
);

  uaddr_t pc_r;
  uaddr_t pc_nxt;
  uaddr_t pc_inc;
  logic   hold;

  assign pc_inc = uaddr_t'(pc_r + 1'b1);
  // wait for a request at fetch, or for the output register on an emitting step
  assign hold   = ((cw.cond == CJ_WAIT_IN) && !in_valid) ||
                  ((cw.emit != EM_NONE) && out_busy);
  assign fire   = !hold;
  assign pc     = pc_r;

  always_comb begin
    pc_nxt = pc_r;
    if (!hold) begin
      unique case (cw.cond)
        CJ_NEXT:     pc_nxt = pc_inc;
        CJ_GOTO:     pc_nxt = cw.target;
        CJ_WAIT_IN:  pc_nxt = pc_inc;
        CJ_ZERO:     pc_nxt = st.radii_zero ? cw.target : pc_inc;
        CJ_DISPATCH: begin
          if (!st.step_op) begin
            pc_nxt = UA_START;
          end else begin
            unique case (st.phase)
              PH_IDLE:    pc_nxt = UA_FETCH;
              PH_REGION1: pc_nxt = UA_R1;
              PH_REGION2: pc_nxt = UA_R2;
              PH_SINGLE:  pc_nxt = UA_SINGLE;
              default:    pc_nxt = UA_FETCH;
            endcase
          end
        end
        default:     pc_nxt = UA_FETCH;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= UA_FETCH;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// File: hw/rtl/eopg_datapath.sv
// ellipse datapath: shared multiplier, error terms, offsets and output register
module eopg_datapath import eopg_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_accept,
  input  logic                    in_opcode,
  input  logic signed [COORD_BITS-1:0] in_center_x,
  input  logic signed [COORD_BITS-1:0] in_center_y,
  input  logic [RADIUS_BITS-1:0]  in_radius_h,
  input  logic [RADIUS_BITS-1:0]  in_radius_v,
  input  ucode_word_t             cw,
  input  logic                    fire,
  input  logic                    out_stall,
  output dp_status_t              st,
  output logic                    out_busy,
  output logic                    out_valid,
  output logic signed [COORD_BITS:0] out_x_right,
  output logic signed [COORD_BITS:0] out_x_left,
  output logic signed [COORD_BITS:0] out_y_down,
  output logic signed [COORD_BITS:0] out_y_up,
  output logic                    out_region,
  output logic                    out_last
);

  localparam int RB = RADIUS_BITS;
  localparam int CB = COORD_BITS;
  localparam int PW = 3 * RB;
  localparam int DW = 3 * RB + 4;
  localparam int OW = RB + 2;
  localparam int SW = ((CB > OW) ? CB : OW) + 1;
  localparam logic signed [OW-1:0] OFS_ONE = OW'(1);

  // request and ellipse parameters
  logic                 in_op_r;
  logic signed [CB-1:0] centre_col_r, centre_row_r;
  logic [RB-1:0]        rad_h_r, rad_v_r;

  // multiplier results
  logic [PW-1:0]   prod_r, prod_nxt;
  logic [2*RB-1:0] asq_r, asq_nxt;
  logic [2*RB-1:0] bsq_r, bsq_nxt;
  logic [PW-1:0]   aab_r, aab_nxt;
  logic [2*RB-1:0] mul_a;
  logic [RB-1:0]   mul_b;
  logic [PW-1:0]   mul_p;

  // walk state
  phase_t                phase_r, phase_nxt;
  logic signed [OW-1:0]  ox_r, ox_nxt, oy_r, oy_nxt;
  logic signed [OW-1:0]  sav_x_r, sav_x_nxt, sav_y_r, sav_y_nxt;
  logic signed [DW-1:0]  xd_r, xd_nxt, yd_r, yd_nxt, err_r, err_nxt;
  logic signed [DW-1:0]  sx_r, sx_nxt, sy_r, sy_nxt;
  logic signed [DW-1:0]  two_h, two_v, asq_w, bsq_w, aab2;
  logic signed [DW+1:0]  r1_test, r2_test;
  logic                  r1_move_x, r2_move_y, fin;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic signed [CB:0]   x_right_r, x_left_r, y_down_r, y_up_r;
  logic                 region_r, last_r;
  logic                 emit_go;
  logic signed [OW-1:0] em_ox, em_oy;
  logic signed [SW-1:0] cen_x_w, cen_y_w, off_x_w, off_y_w;
  logic signed [SW-1:0] xr_w, xl_w, yd_w, yu_w;

  assign two_h = {{(DW-2*RB-1){1'b0}}, asq_r, 1'b0};
  assign two_v = {{(DW-2*RB-1){1'b0}}, bsq_r, 1'b0};
  assign asq_w = {{(DW-2*RB){1'b0}}, asq_r};
  assign bsq_w = {{(DW-2*RB){1'b0}}, bsq_r};
  assign aab2  = {{(DW-PW-1){1'b0}}, aab_r, 1'b0};

  // 2*err + delta, sign and zero decide the diagonal move
  assign r1_test   = {err_r[DW-1], err_r, 1'b0} + {{2{xd_r[DW-1]}}, xd_r};
  assign r2_test   = {err_r[DW-1], err_r, 1'b0} + {{2{yd_r[DW-1]}}, yd_r};
  assign r1_move_x = !r1_test[DW+1] && (r1_test != '0);
  assign r2_move_y = !r2_test[DW+1] && (r2_test != '0);
  assign fin       = sx_r > sy_r;

  // one shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cw.op)
      DP_MUL_AA:  begin mul_a = {{RB{1'b0}}, rad_h_r}; mul_b = rad_h_r; end
      DP_MUL_BB:  begin mul_a = {{RB{1'b0}}, rad_v_r}; mul_b = rad_v_r; end
      DP_MUL_BBA: begin mul_a = prod_r[2*RB-1:0];      mul_b = rad_h_r; end
      DP_MUL_AAB: begin mul_a = asq_r;                 mul_b = rad_v_r; end
      default:    begin mul_a = '0;                    mul_b = '0;      end
    endcase
  end
  assign mul_p = {{RB{1'b0}}, mul_a} * {{(2*RB){1'b0}}, mul_b};

  always_comb begin
    prod_nxt  = prod_r;
    asq_nxt   = asq_r;
    bsq_nxt   = bsq_r;
    aab_nxt   = aab_r;
    phase_nxt = phase_r;
    ox_nxt    = ox_r;
    oy_nxt    = oy_r;
    sav_x_nxt = sav_x_r;
    sav_y_nxt = sav_y_r;
    xd_nxt    = xd_r;
    yd_nxt    = yd_r;
    err_nxt   = err_r;
    sx_nxt    = sx_r;
    sy_nxt    = sy_r;
    if (fire) begin
      unique case (cw.op)
        DP_MUL_AA: prod_nxt = mul_p;
        DP_MUL_BB: begin
          asq_nxt  = prod_r[2*RB-1:0];
          prod_nxt = mul_p;
        end
        DP_MUL_BBA: begin
          bsq_nxt  = prod_r[2*RB-1:0];
          prod_nxt = mul_p;
        end
        DP_MUL_AAB: begin
          sx_nxt   = {{(DW-PW-1){1'b0}}, prod_r, 1'b0};
          prod_nxt = mul_p;
        end
        DP_INIT_R1: begin
          aab_nxt   = prod_r;
          ox_nxt    = {2'b00, rad_h_r};
          oy_nxt    = '0;
          xd_nxt    = bsq_w - sx_r;
          yd_nxt    = asq_w;
          err_nxt   = '0;
          sy_nxt    = '0;
          phase_nxt = PH_REGION1;
        end
        DP_ZERO: begin
          ox_nxt    = '0;
          oy_nxt    = '0;
          phase_nxt = PH_SINGLE;
        end
        DP_IDLE: phase_nxt = PH_IDLE;
        DP_R1_Y: begin
          oy_nxt  = oy_r + OFS_ONE;
          sy_nxt  = sy_r + two_h;
          err_nxt = err_r + yd_r;
          yd_nxt  = yd_r + two_h;
        end
        DP_R1_X: begin
          if (r1_move_x) begin
            ox_nxt  = ox_r - OFS_ONE;
            sx_nxt  = sx_r - two_v;
            err_nxt = err_r + xd_r;
            xd_nxt  = xd_r + two_v;
          end
        end
        DP_R1_END: begin
          // flat part reached: restart at the top of the ellipse
          if (sx_r < sy_r) begin
            ox_nxt    = '0;
            oy_nxt    = {2'b00, rad_v_r};
            xd_nxt    = bsq_w;
            yd_nxt    = asq_w - aab2;
            err_nxt   = '0;
            sx_nxt    = '0;
            sy_nxt    = aab2;
            phase_nxt = PH_REGION2;
          end
        end
        DP_R2_X: begin
          sav_x_nxt = ox_r;
          sav_y_nxt = oy_r;
          ox_nxt    = ox_r + OFS_ONE;
          sx_nxt    = sx_r + two_v;
          err_nxt   = err_r + xd_r;
          xd_nxt    = xd_r + two_v;
        end
        DP_R2_Y: begin
          if (r2_move_y) begin
            oy_nxt  = oy_r - OFS_ONE;
            sy_nxt  = sy_r - two_h;
            err_nxt = err_r + yd_r;
            yd_nxt  = yd_r + two_h;
          end
        end
        DP_R2_END: begin
          if (fin) begin
            phase_nxt = PH_IDLE;
          end
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // output point set
  assign emit_go = fire && (cw.emit != EM_NONE);
  assign em_ox   = (cw.emit == EM_R2) ? sav_x_r : ox_r;
  assign em_oy   = (cw.emit == EM_R2) ? sav_y_r : oy_r;
  assign cen_x_w = SW'(centre_col_r);
  assign cen_y_w = SW'(centre_row_r);
  assign off_x_w = SW'(em_ox);
  assign off_y_w = SW'(em_oy);
  assign xr_w    = cen_x_w + off_x_w;
  assign xl_w    = cen_x_w - off_x_w;
  assign yd_w    = cen_y_w + off_y_w;
  assign yu_w    = cen_y_w - off_y_w;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    asq_r   <= asq_nxt;
    bsq_r   <= bsq_nxt;
    aab_r   <= aab_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    sav_x_r <= sav_x_nxt;
    sav_y_r <= sav_y_nxt;
    xd_r    <= xd_nxt;
    yd_r    <= yd_nxt;
    err_r   <= err_nxt;
    sx_r    <= sx_nxt;
    sy_r    <= sy_nxt;
    if (in_accept) begin
      in_op_r <= in_opcode;
      if (in_opcode == OP_START) begin
        centre_col_r <= in_center_x;
        centre_row_r <= in_center_y;
        rad_h_r      <= in_radius_h;
        rad_v_r      <= in_radius_v;
      end
    end
    if (emit_go) begin
      x_right_r <= xr_w[CB:0];
      x_left_r  <= xl_w[CB:0];
      y_down_r  <= yd_w[CB:0];
      y_up_r    <= yu_w[CB:0];
      region_r  <= (cw.emit == EM_R2);
      last_r    <= (cw.emit == EM_SINGLE) || ((cw.emit == EM_R2) && fin);
    end
  end

  assign st.phase      = phase_r;
  assign st.step_op    = (in_op_r == OP_STEP);
  assign st.radii_zero = (rad_h_r == '0) && (rad_v_r == '0);

  assign out_busy    = out_valid_r && out_stall;
  assign out_valid   = out_valid_r;
  assign out_x_right = x_right_r;
  assign out_x_left  = x_left_r;
  assign out_y_down  = y_down_r;
  assign out_y_up    = y_up_r;
  assign out_region  = region_r;
  assign out_last    = last_r;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench of the ellipse outline point generator unit
module testbench;
  import eopg_pkg::*;

  localparam int  CB            = COORD_BITS_DEF;
  localparam int  RB            = RADIUS_BITS_DEF;
  localparam int  HOLD_CYCLES   = 600;
  localparam int  RANDOM_REQS   = 350;
  localparam int  LARGEST_STEPS = 40;
  localparam int  DRAIN_WAIT    = 30;
  // slowest pass: every request with the longest gap and stall plus its own cycles, many times over
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic [CB:0] x_right;
    logic [CB:0] x_left;
    logic [CB:0] y_down;
    logic [CB:0] y_up;
    logic        region;
    logic        last;
  } point_set_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_opcode;
  logic signed [CB-1:0] in_center_x;
  logic signed [CB-1:0] in_center_y;
  logic [RB-1:0]        in_radius_h;
  logic [RB-1:0]        in_radius_v;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [CB:0]   out_x_right;
  logic signed [CB:0]   out_x_left;
  logic signed [CB:0]   out_y_down;
  logic signed [CB:0]   out_y_up;
  logic                 out_region;
  logic                 out_last;

  ellipse_outline_point_generator_unit #(
    .COORD_BITS (CB),
    .RADIUS_BITS(RB)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_opcode  (in_opcode),
    .in_center_x(in_center_x),
    .in_center_y(in_center_y),
    .in_radius_h(in_radius_h),
    .in_radius_v(in_radius_v),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_x_right(out_x_right),
    .out_x_left (out_x_left),
    .out_y_down (out_y_down),
    .out_y_up   (out_y_up),
    .out_region (out_region),
    .out_last   (out_last)
  );

  // outline predictor state, kept in wide integers so nothing overflows
  phase_t ell_phase;
  longint ctr_col, ctr_row;
  longint off_x, off_y;
  longint inc_x, inc_y, err_acc;
  longint bound_x, bound_y;
  longint twice_aa, twice_bb;
  longint rad_a, rad_b;

  point_set_t expected_points[$];

  // run bookkeeping
  int     errors        = 0;
  int     busy_requests = 0;
  int     starts_sent   = 0;
  int     steps_sent    = 0;
  int     points_seen   = 0;
  int     outlines_done = 0;
  int     hold_tickets  = 0;
  logic   quiet_mode    = 1'b0;
  longint cycle_count   = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // watchdog: a hung block ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // four mirrored pixels at the given offsets, wrapped to the output width
  function automatic point_set_t point_at(longint ox, longint oy, logic reg_two, logic fin);
    point_set_t p;
    p.x_right = (CB+1)'(ctr_col + ox);
    p.x_left  = (CB+1)'(ctr_col - ox);
    p.y_down  = (CB+1)'(ctr_row + oy);
    p.y_up    = (CB+1)'(ctr_row - oy);
    p.region  = reg_two;
    p.last    = fin;
    return p;
  endfunction

  task automatic predict_request(input logic op, input logic signed [CB-1:0] cx,
                                 input logic signed [CB-1:0] cy, input logic [RB-1:0] rh,
                                 input logic [RB-1:0] rv);
    longint sx, sy;
    logic   fin;
    if (op == OP_START) begin
      // a start abandons whatever outline was in progress
      rad_a    = rh;
      rad_b    = rv;
      ctr_col  = cx;
      ctr_row  = cy;
      twice_aa = 2 * rad_a * rad_a;
      twice_bb = 2 * rad_b * rad_b;
      err_acc  = 0;
      off_y    = 0;
      bound_y  = 0;
      if (rad_a == 0 && rad_b == 0) begin
        // degenerate outline: just the centre pixel
        off_x     = 0;
        inc_x     = 0;
        inc_y     = 0;
        bound_x   = 0;
        ell_phase = PH_SINGLE;
      end else begin
        off_x     = rad_a;
        inc_x     = rad_b * rad_b * (1 - 2 * rad_a);
        inc_y     = rad_a * rad_a;
        bound_x   = twice_bb * rad_a;
        ell_phase = PH_REGION1;
      end
      return;
    end
    case (ell_phase)
      PH_SINGLE: begin
        expected_points.push_back(point_at(off_x, off_y, 1'b0, 1'b1));
        ell_phase = PH_IDLE;
      end
      PH_REGION1: begin
        // steep part: y moves every step, x only when the midpoint falls outside
        expected_points.push_back(point_at(off_x, off_y, 1'b0, 1'b0));
        off_y   += 1;
        bound_y += twice_aa;
        err_acc += inc_y;
        inc_y   += twice_aa;
        if (2 * err_acc + inc_x > 0) begin
          off_x   -= 1;
          bound_x -= twice_bb;
          err_acc += inc_x;
          inc_x   += twice_bb;
        end
        if (!(bound_x >= bound_y)) begin
          // hand over to the flat part, which restarts from the top of the outline
          off_x     = 0;
          off_y     = rad_b;
          inc_x     = rad_b * rad_b;
          inc_y     = rad_a * rad_a * (1 - 2 * rad_b);
          err_acc   = 0;
          bound_x   = 0;
          bound_y   = twice_aa * rad_b;
          ell_phase = PH_REGION2;
        end
      end
      PH_REGION2: begin
        // flat part: the point set shows the offsets before this step's update
        sx = off_x;
        sy = off_y;
        off_x   += 1;
        bound_x += twice_bb;
        err_acc += inc_x;
        inc_x   += twice_bb;
        if (2 * err_acc + inc_y > 0) begin
          off_y   -= 1;
          bound_y -= twice_aa;
          err_acc += inc_y;
          inc_y   += twice_aa;
        end
        fin = !(bound_x <= bound_y);
        expected_points.push_back(point_at(sx, sy, 1'b1, fin));
        if (fin) ell_phase = PH_IDLE;
      end
      default: ;  // step while idle: nothing comes out
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // mostly back to back, sometimes a short pause, now and then a long one
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_mode || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // offer one request and return at the edge that took it, valid still high
  task automatic send_request(input logic op, input logic signed [CB-1:0] cx,
                              input logic signed [CB-1:0] cy, input logic [RB-1:0] rh,
                              input logic [RB-1:0] rv);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_center_x <= cx;
    in_center_y <= cy;
    in_radius_h <= rh;
    in_radius_v <= rv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == OP_START) starts_sent++;
    else steps_sent++;
    // steps while idle are ignored by the block and do not count as work
    if (op == OP_START || ell_phase != PH_IDLE) busy_requests++;
    predict_request(op, cx, cy, rh, rv);
  endtask

  // a step request carries junk in the fields it ignores
  task automatic send_step();
    send_request(OP_STEP, CB'($urandom), CB'($urandom), RB'($urandom), RB'($urandom));
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // the sender pauses until every predicted point set has come back
  task automatic wait_drained();
    release_input();
    while (expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // start an outline and step it to its end, or abandon it after a number of steps
  task automatic draw_ellipse(input logic signed [CB-1:0] cx, input logic signed [CB-1:0] cy,
                              input logic [RB-1:0] a, input logic [RB-1:0] b,
                              input int abandon_after);
    int n;
    n = 0;
    send_request(OP_START, cx, cy, a, b);
    while (ell_phase != PH_IDLE && (abandon_after < 0 || n < abandon_after)) begin
      send_step();
      n++;
    end
  endtask

  // most radii small, a few up to the largest
  function automatic logic [RB-1:0] pick_radius();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)  return '0;
    if (r < 75) return RB'($urandom_range(1, 12));
    if (r < 93) return RB'($urandom_range(13, 63));
    if (r < 98) return RB'($urandom_range(64, 255));
    return RB'($urandom_range(256, (1 << RB) - 1));
  endfunction

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // random stalls, plus one long hold-off whenever a ticket is raised
  initial begin : result_sink
    int   r;
    int   run;
    logic hold;
    int   served;
    served = 0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (served != hold_tickets) begin
        served = hold_tickets;
        hold   = 1'b1;
        run    = HOLD_CYCLES;
      end else if (quiet_mode || r < 55) begin
        hold = 1'b0;
        run  = $urandom_range(1, 8);
      end else if (r < 90) begin
        hold = 1'b1;
        run  = $urandom_range(1, 3);
      end else if (r < 97) begin
        hold = 1'b1;
        run  = $urandom_range(4, 12);
      end else begin
        hold = 1'b1;
        run  = $urandom_range(20, 60);
      end
      out_stall <= hold;
      repeat (run) @(posedge clk);
    end
  end

  task automatic check_field(input string name, input logic [CB:0] want, input logic [CB:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, $signed(want), $signed(got));
      errors++;
    end
  endtask

  // each point set taken from the block is held against the oldest prediction
  always @(posedge clk) begin : point_checker
    point_set_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        $error("point set with nothing predicted: x_right %0d y_down %0d region %0d last %0d",
               out_x_right, out_y_down, out_region, out_last);
        errors++;
      end else begin
        want = expected_points.pop_front();
        check_field("x_right", want.x_right, out_x_right);
        check_field("x_left", want.x_left, out_x_left);
        check_field("y_down", want.y_down, out_y_down);
        check_field("y_up", want.y_up, out_y_up);
        check_field("region", {{CB{1'b0}}, want.region}, {{CB{1'b0}}, out_region});
        check_field("last", {{CB{1'b0}}, want.last}, {{CB{1'b0}}, out_last});
        points_seen++;
        if (out_last) outlines_done++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // steps with nothing started give nothing
  task automatic test_idle_steps();
    repeat (3) send_step();
  endtask

  // both radii zero: one centre point marked last, then idle again
  task automatic test_single_point();
    draw_ellipse(CB'(2047), -CB'(2048), '0, '0, -1);
    send_step();
    // a start on top of a pending single point replaces it
    send_request(OP_START, '0, '0, '0, '0);
    draw_ellipse(-CB'(7), CB'(11), RB'(2), RB'(1), -1);
  endtask

  // one radius zero: the normal stepping ends by itself
  task automatic test_flat_radii();
    draw_ellipse(CB'(5), -CB'(9), RB'(5), '0, -1);
    draw_ellipse(-CB'(3), CB'(4), '0, RB'(5), -1);
    draw_ellipse(CB'(2047), CB'(2047), RB'(1023), '0, -1);
    draw_ellipse(-CB'(2048), -CB'(2048), '0, RB'(1023), -1);
  endtask

  // small outlines at the corners of the coordinate range, a large one abandoned, and restarts while busy
  task automatic test_restart();
    draw_ellipse(-CB'(2048), -CB'(2048), RB'(1), RB'(1), -1);
    draw_ellipse(CB'(2047), CB'(2047), RB'(3), RB'(2), -1);
    draw_ellipse(-CB'(2048), CB'(2047), RB'(1023), RB'(1023), 6);
    draw_ellipse(CB'(100), -CB'(100), RB'(4), RB'(7), -1);
    send_request(OP_START, CB'(1), CB'(2), RB'(9), RB'(9));
    draw_ellipse(CB'(0), CB'(0), RB'(6), RB'(3), -1);
  endtask

  // the largest outline for a stretch: widest error terms and the far column ends
  task automatic test_largest();
    draw_ellipse(-CB'(2048), CB'(2047), RB'(1023), RB'(1023), LARGEST_STEPS);
    wait_drained();
  endtask

  // long output hold-off while requests keep coming, so the input backs up
  task automatic test_back_pressure();
    send_request(OP_START, CB'(-300), CB'(250), RB'(40), RB'(25));
    hold_tickets++;
    while (ell_phase != PH_IDLE) send_step();
    wait_drained();
  endtask

  // a stretch with no gaps and no stalls on either side
  task automatic test_full_rate();
    quiet_mode = 1'b1;
    repeat (6) draw_ellipse(CB'($urandom), CB'($urandom), RB'($urandom_range(0, 20)),
                            RB'($urandom_range(0, 20)), -1);
    quiet_mode = 1'b0;
    wait_drained();
  endtask

  // well-formed outlines with random content, mixed with stray steps and starts
  task automatic test_random_traffic();
    int base;
    int r;
    int left;
    base = busy_requests;
    while (busy_requests - base < RANDOM_REQS) begin
      left = RANDOM_REQS - (busy_requests - base);
      r    = $urandom_range(0, 99);
      if (r < 80)
        draw_ellipse(CB'($urandom), CB'($urandom), pick_radius(), pick_radius(),
                     ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 20)) : left - 1);
      else if (r < 90)
        send_step();
      else
        send_request(OP_START, CB'($urandom), CB'($urandom), pick_radius(), pick_radius());
    end
  endtask

  initial begin
    ell_phase = PH_IDLE;
    ctr_col   = 0;
    ctr_row   = 0;
    off_x     = 0;
    off_y     = 0;
    inc_x     = 0;
    inc_y     = 0;
    err_acc   = 0;
    bound_x   = 0;
    bound_y   = 0;
    twice_aa  = 0;
    twice_bb  = 0;
    rad_a     = 0;
    rad_b     = 0;

    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_opcode   <= OP_STEP;
    in_center_x <= '0;
    in_center_y <= '0;
    in_radius_h <= '0;
    in_radius_v <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_steps();
    test_single_point();
    test_flat_radii();
    test_restart();
    test_largest();
    test_back_pressure();
    test_full_rate();
    test_random_traffic();

    wait_drained();

    $display("covered %0d starts and %0d steps; %0d point sets checked in %0d finished outlines",
             starts_sent, steps_sent, points_seen, outlines_done);
    $display("incl. zero and one-sided radii, radius 1023, restarts, long hold-off, full rate");
    if (errors == 0 && expected_points.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
